@@ rtl/core/ilid_pkg.sv @@
// shared types, codes and widths for the indexed list core
package ilid_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int CMD_W    = 2;
	localparam int INDEX_W  = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int LENGTH_W = 7;

	localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	// broadcast to every cell of the row
	typedef struct packed {
		logic               we;
		logic [CMD_W-1:0]   cmd;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

@@ rtl/core/ilid_cell.sv @@
// one word of the list: holds, loads, or takes a neighbor's word
module ilid_cell #(
	parameter int POS = 0
) (
	input  logic                             clk,
	input  ilid_pkg::cell_ctrl_t             ctrl,
	input  logic [ilid_pkg::VALUE_W-1:0]     left_word,
	input  logic [ilid_pkg::VALUE_W-1:0]     right_word,
	output logic [ilid_pkg::VALUE_W-1:0]     word,
	output logic [ilid_pkg::VALUE_W-1:0]     rd_word
);

	localparam int PB = $clog2(POS + 1);
	localparam int PW = (PB > ilid_pkg::INDEX_W) ? PB : ilid_pkg::INDEX_W;
	localparam logic [PW-1:0] POS_V = PW'(POS);

	logic [ilid_pkg::VALUE_W-1:0] data_q;
	logic [PW-1:0]                idx_w;
	logic                         hit;
	logic                         above;

	assign idx_w = PW'(ctrl.index);
	assign hit   = (idx_w == POS_V);
	assign above = (POS_V > idx_w);

	always_ff @(posedge clk) begin
		if (ctrl.we) begin
			unique case (ctrl.cmd)
				ilid_pkg::CMD_READ: begin
					data_q <= data_q;
				end
				ilid_pkg::CMD_UPDATE: begin
					if (hit) data_q <= ctrl.value;
				end
				ilid_pkg::CMD_INSERT: begin
					if (hit) data_q <= ctrl.value;
					else if (above) data_q <= left_word;
				end
				ilid_pkg::CMD_DELETE: begin
					if (hit || above) data_q <= right_word;
				end
			endcase
		end
	end

	assign word    = data_q;
	assign rd_word = hit ? data_q : '0;

endmodule

@@ rtl/core/indexed_list_insert_delete_core.sv @@
// Ordered list of signed 32-bit words held in a row of CAPACITY register cells. Each command
// beat (read, update, insert before index, delete at index) takes effect when accepted, since
// each cell that changes loads its new word in that same cycle, so the block takes one command
// per cycle when the output side keeps up. The result is registered on its way out: the
// read path first ORs the cells in groups of 32 into registers, then merges the groups.
// Status 1 flags an index out of range (insert allows index equal to length), status 2 an
// insert into a full list; in both cases nothing changes. No clearing pass after reset.
module indexed_list_insert_delete_core #(
	parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [1:0] command, [8:2] index, [40:9] value, [47:41] zero
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [1:0] status, [33:2] read_value, [40:34] length, [47:41] zero
	output logic [47:0] m_tdata
);

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int EW = (LW > ilid_pkg::INDEX_W) ? LW : ilid_pkg::INDEX_W;
	localparam int OW = (LW > ilid_pkg::LENGTH_W) ? LW : ilid_pkg::LENGTH_W;
	localparam int G  = 32;
	localparam int NG = (CAPACITY + G - 1) / G;
	localparam int VW = ilid_pkg::VALUE_W;

	logic [ilid_pkg::CMD_W-1:0]    cmd;
	logic [ilid_pkg::INDEX_W-1:0]  idx;
	logic [VW-1:0]                 val;
	logic [EW-1:0]                 idx_e;
	logic [EW-1:0]                 len_e;
	logic [ilid_pkg::STATUS_W-1:0] status;
	logic                          ok;
	logic                          accept;
	logic [LW-1:0]                 len_q;
	logic [LW-1:0]                 len_next;
	logic [OW-1:0]                 len_o;
	ilid_pkg::cell_ctrl_t          ctrl;

	logic [CAPACITY-1:0][VW-1:0]   word;
	logic [CAPACITY-1:0][VW-1:0]   rd_word;
	logic [NG-1:0][VW-1:0]         grp_or;

	logic                          v_s1;
	logic [ilid_pkg::STATUS_W-1:0] status_s1;
	logic                          rd_ok_s1;
	logic [ilid_pkg::LENGTH_W-1:0] len_s1;
	logic [NG-1:0][VW-1:0]         grp_s1;

	logic                          v_s2;
	logic [ilid_pkg::STATUS_W-1:0] status_s2;
	logic [VW-1:0]                 rd_s2;
	logic [ilid_pkg::LENGTH_W-1:0] len_s2;
	logic [VW-1:0]                 rd_merge;

	logic                          s2_ready;
	logic                          s1_ready;

	assign cmd   = s_tdata[1:0];
	assign idx   = s_tdata[8:2];
	assign val   = s_tdata[40:9];
	assign idx_e = EW'(idx);
	assign len_e = EW'(len_q);

	always_comb begin
		status = ilid_pkg::ST_DONE;
		unique case (cmd)
			ilid_pkg::CMD_READ, ilid_pkg::CMD_UPDATE, ilid_pkg::CMD_DELETE: begin
				if (!(idx_e < len_e)) status = ilid_pkg::ST_INVALID;
			end
			ilid_pkg::CMD_INSERT: begin
				if (idx_e > len_e) status = ilid_pkg::ST_INVALID;
				else if (len_e == EW'(CAPACITY)) status = ilid_pkg::ST_FULL;
			end
		endcase
	end

	assign ok     = (status == ilid_pkg::ST_DONE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		len_next = len_q;
		if (ok && cmd == ilid_pkg::CMD_INSERT) len_next = len_q + LW'(1);
		else if (ok && cmd == ilid_pkg::CMD_DELETE) len_next = len_q - LW'(1);
	end

	assign len_o = OW'(len_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (accept) begin
			len_q <= len_next;
		end
	end

	assign ctrl.we    = accept && ok && (cmd != ilid_pkg::CMD_READ);
	assign ctrl.cmd   = cmd;
	assign ctrl.index = idx;
	assign ctrl.value = val;

	// row of cells, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VW-1:0] left_w;
		logic [VW-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = word[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = word[i+1];
		end
		ilid_cell #(
			.POS(i)
		) u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.left_word (left_w),
			.right_word(right_w),
			.word      (word[i]),
			.rd_word   (rd_word[i])
		);
	end

	// only the addressed cell drives a nonzero word
	always_comb begin
		grp_or = '0;
		for (int g = 0; g < NG; g++) begin
			for (int k = 0; k < G; k++) begin
				if (g * G + k < CAPACITY) grp_or[g] = grp_or[g] | rd_word[g * G + k];
			end
		end
	end

	assign s2_ready = !v_s2 || m_tready;
	assign s1_ready = !v_s1 || s2_ready;
	assign s_tready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s1_ready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status;
			rd_ok_s1  <= ok && (cmd == ilid_pkg::CMD_READ);
			len_s1    <= len_o[ilid_pkg::LENGTH_W-1:0];
			grp_s1    <= grp_or;
		end
	end

	always_comb begin
		rd_merge = '0;
		for (int g = 0; g < NG; g++) begin
			rd_merge = rd_merge | grp_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_ready && v_s1) begin
			status_s2 <= status_s1;
			rd_s2     <= rd_ok_s1 ? rd_merge : '0;
			len_s2    <= len_s1;
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata  = {7'd0, len_s2, rd_s2, status_s2};

endmodule

@@ rtl/core/ilid_checker.sv @@
// port-level checks for the indexed list core, bound to the top level
module ilid_checker #(
	parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	logic [1:0] st;
	logic [6:0] len;

	assign st  = m_tdata[1:0];
	assign len = m_tdata[40:34];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed while stalled");

	a_zero_rd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && st != ilid_pkg::ST_DONE |-> m_tdata[33:2] == 32'd0)
		else $error("read word nonzero on a failed command");

	// an accepted beat always leaves an output beat waiting once it has passed the pipeline registers
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("no output beat two cycles after an accepted beat");

	if (CAPACITY < 128) begin : g_small
		a_full: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid && st == ilid_pkg::ST_FULL |-> len == 7'(CAPACITY))
			else $error("full status while list not full");

		a_len: assert property (@(posedge clk) disable iff (!arst_n)
			m_tvalid |-> len <= 7'(CAPACITY))
			else $error("length above capacity");
	end

endmodule

bind indexed_list_insert_delete_core ilid_checker #(
	.CAPACITY(CAPACITY)
) u_ilid_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);
